@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

@@ rtl/core/mce_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor current end-stop controller package
// Types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package mce_pkg;

  localparam int SampleWidth = 8;
  localparam int CountWidth  = 5;
  localparam int LimitWidth  = 8;
  localparam int CmdWidth    = 8;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 8;

  localparam logic [CmdWidth-1:0] CmdLedOn     = 8'h62;
  localparam logic [CmdWidth-1:0] CmdLedOff    = 8'h65;
  localparam logic [CmdWidth-1:0] CmdMotorOn   = 8'h42;
  localparam logic [CmdWidth-1:0] CmdMotorOff  = 8'h45;
  localparam logic [CmdWidth-1:0] CmdOpenMain  = 8'h6f;
  localparam logic [CmdWidth-1:0] CmdOpenAlt   = 8'h4f;
  localparam logic [CmdWidth-1:0] CmdCloseMain = 8'h63;
  localparam logic [CmdWidth-1:0] CmdCloseAlt  = 8'h43;

  localparam logic [LimitWidth-1:0] OpenMainReset  = 8'h8e;
  localparam logic [LimitWidth-1:0] OpenAltReset   = 8'h01;
  localparam logic [LimitWidth-1:0] CloseMainReset = 8'h6e;
  localparam logic [LimitWidth-1:0] CloseAltReset  = 8'h50;
  localparam logic [CountWidth-1:0] BlankingReset  = 5'd25;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegOpenMain  = 3'd0,
    RegOpenAlt   = 3'd1,
    RegCloseMain = 3'd2,
    RegCloseAlt  = 3'd3,
    RegBlanking  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModeIdle  = 2'd0,
    ModeOpen  = 2'd1,
    ModeClose = 2'd2
  } mode_e;

  typedef enum logic {
    OpCommand = 1'b0,
    OpSample  = 1'b1
  } op_e;

  typedef struct packed {
    logic [LimitWidth-1:0] open_main;
    logic [LimitWidth-1:0] open_alt;
    logic [LimitWidth-1:0] close_main;
    logic [LimitWidth-1:0] close_alt;
    logic [CountWidth-1:0] blanking;
  } cfg_t;

  typedef struct packed {
    logic                   operation;
    logic [CmdWidth-1:0]    command_byte;
    logic [SampleWidth-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic                   led_on;
    logic                   motor_on;
    logic                   direction_high;
    logic                   moving;
    logic                   echo_valid;
    logic [SampleWidth-1:0] echo_sample;
  } result_t;

endpackage

@@ rtl/core/mce_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four current limits and the blanking count.
// ----------------------------------------------------------------------------
module mce_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mce_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [mce_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  output mce_pkg::cfg_t                     cfg_o
);
  import mce_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOpenMain:  cfg_d.open_main  = cfg_wdata_i[LimitWidth-1:0];
        RegOpenAlt:   cfg_d.open_alt   = cfg_wdata_i[LimitWidth-1:0];
        RegCloseMain: cfg_d.close_main = cfg_wdata_i[LimitWidth-1:0];
        RegCloseAlt:  cfg_d.close_alt  = cfg_wdata_i[LimitWidth-1:0];
        RegBlanking:  cfg_d.blanking   = cfg_wdata_i[CountWidth-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_main  <= OpenMainReset;
      cfg_q.open_alt   <= OpenAltReset;
      cfg_q.close_main <= CloseMainReset;
      cfg_q.close_alt  <= CloseAltReset;
      cfg_q.blanking   <= BlankingReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/mce_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input register
// Captures one command or sample transfer and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module mce_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mce_pkg::item_t item_i,
  output logic           item_valid_o,
  output mce_pkg::item_t item_o,
  input  logic           take_i
);
  import mce_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  accept;

  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (accept) begin
      vld_d  = 1'b1;
      item_d = item_i;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

@@ rtl/core/mce_core.sv @@
// ----------------------------------------------------------------------------
// Controller core
// Decodes commands, tracks the move and checks samples against the limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mce_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mce_pkg::cfg_t    cfg_i,
  input  logic             step_i,
  input  mce_pkg::item_t   item_i,
  output mce_pkg::result_t result_o
);
  import mce_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [LimitWidth-1:0] thr_q, thr_d;
  logic                  led_q, led_d;
  logic                  motor_q, motor_d;
  logic                  dir_q, dir_d;
  logic                  moving;
  logic                  echo;
  logic                  hit;
  logic                  start;
  mode_e                 start_mode;
  logic [LimitWidth-1:0] start_limit;

  assign moving = (mode_q != ModeIdle);

  always_comb begin
    start       = 1'b0;
    start_mode  = ModeOpen;
    start_limit = cfg_i.open_main;
    unique case (item_i.command_byte)
      CmdOpenMain: begin
        start       = 1'b1;
        start_mode  = ModeOpen;
        start_limit = cfg_i.open_main;
      end
      CmdOpenAlt: begin
        start       = 1'b1;
        start_mode  = ModeOpen;
        start_limit = cfg_i.open_alt;
      end
      CmdCloseMain: begin
        start       = 1'b1;
        start_mode  = ModeClose;
        start_limit = cfg_i.close_main;
      end
      CmdCloseAlt: begin
        start       = 1'b1;
        start_mode  = ModeClose;
        start_limit = cfg_i.close_alt;
      end
      default: start = 1'b0;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    count_d = count_q;
    thr_d   = thr_q;
    led_d   = led_q;
    motor_d = motor_q;
    dir_d   = dir_q;
    echo    = 1'b0;
    hit     = 1'b0;
    if (item_i.operation == OpCommand) begin
      if (!moving) begin
        if (start) begin
          mode_d  = start_mode;
          count_d = '0;
          thr_d   = start_limit;
          led_d   = 1'b1;
          motor_d = 1'b1;
          dir_d   = (start_mode == ModeOpen);
        end else begin
          unique case (item_i.command_byte)
            CmdLedOn:    led_d   = 1'b1;
            CmdLedOff:   led_d   = 1'b0;
            CmdMotorOn:  motor_d = 1'b1;
            CmdMotorOff: motor_d = 1'b0;
            default:     led_d   = led_q;
          endcase
        end
      end
    end else if (moving) begin
      echo = 1'b1;
      if (count_q < cfg_i.blanking) begin
        count_d = count_q + CountWidth'(1);
      end
      if (count_d >= cfg_i.blanking) begin
        if (mode_q == ModeOpen) begin
          hit = (item_i.adc_sample >= SampleWidth'(thr_q));
        end else begin
          hit = (item_i.adc_sample <= SampleWidth'(thr_q));
        end
      end
      if (hit) begin
        dir_d   = (mode_q != ModeOpen);
        motor_d = 1'b0;
        led_d   = 1'b0;
        mode_d  = ModeIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      count_q <= '0;
      thr_q   <= '0;
      led_q   <= 1'b0;
      motor_q <= 1'b0;
      dir_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      thr_q   <= thr_d;
      led_q   <= led_d;
      motor_q <= motor_d;
      dir_q   <= dir_d;
    end
  end

  always_comb begin
    result_o.led_on         = led_d;
    result_o.motor_on       = motor_d;
    result_o.direction_high = dir_d;
    result_o.moving         = (mode_d != ModeIdle);
    result_o.echo_valid     = echo;
    result_o.echo_sample    = echo ? item_i.adc_sample : '0;
  end

  `ASSERT_PROP(a_move_drives_outputs, clk_i, rst_ni, moving |-> (motor_q && led_q))
  `ASSERT_PROP(a_open_dir_high, clk_i, rst_ni, (mode_q == ModeOpen) |-> dir_q)
  `ASSERT_PROP(a_close_dir_low, clk_i, rst_ni, (mode_q == ModeClose) |-> !dir_q)
  `ASSERT_PROP(a_mode_holds_without_step, clk_i, rst_ni, !step_i |=> $stable(mode_q))

endmodule

@@ rtl/core/mce_out_stage.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the receiving side takes the transfer.
// ----------------------------------------------------------------------------
module mce_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mce_pkg::result_t result_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mce_pkg::result_t result_o
);
  import mce_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q, res_d;

  assign ready_o = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (load_i) begin
      vld_d = 1'b1;
      res_d = result_i;
    end else if (ready_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

@@ rtl/core/motor_current_endstop_controller.sv @@
// ----------------------------------------------------------------------------
// Motor current end-stop controller
// Command decoder and current-limit end stop for a small motor drive.
// ----------------------------------------------------------------------------
// The block takes one command or sample transfer per clock cycle while the
// output is not stalled, and gives exactly one result per transfer: each
// transfer passes through the input register and then the result register.
// The rate is set by the state update in the core, which decodes a command
// or compares a sample against the active limit. Configuration writes take
// effect at the next edge and should be made only while no transfer is in
// flight.
module motor_current_endstop_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mce_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [mce_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [mce_pkg::CmdWidth-1:0]      command_byte_i,
  input  logic [mce_pkg::SampleWidth-1:0]   adc_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              led_on_o,
  output logic                              motor_on_o,
  output logic                              direction_high_o,
  output logic                              moving_o,
  output logic                              echo_valid_o,
  output logic [mce_pkg::SampleWidth-1:0]   echo_sample_o
);
  import mce_pkg::*;

  cfg_t    cfg;
  item_t   item_in;
  item_t   item;
  logic    item_valid;
  logic    out_ready;
  logic    step;
  result_t core_res;
  result_t out_res;

  assign item_in.operation    = operation_i;
  assign item_in.command_byte = command_byte_i;
  assign item_in.adc_sample   = adc_sample_i;

  assign step = item_valid & out_ready;

  mce_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mce_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (out_ready)
  );

  mce_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (item),
    .result_o (core_res)
  );

  mce_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (core_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign led_on_o         = out_res.led_on;
  assign motor_on_o       = out_res.motor_on;
  assign direction_high_o = out_res.direction_high;
  assign moving_o         = out_res.moving;
  assign echo_valid_o     = out_res.echo_valid;
  assign echo_sample_o    = out_res.echo_sample;

endmodule
